@@ design/mmlt_pkg.sv @@
// Shared types and constants of the min/max LTTB downsampler.
`timescale 1ns / 1ps
package mmlt_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_GOAL_POINTS  = 2'd1;
  localparam logic [1:0] REG_RATIO_Q4     = 2'd2;
  localparam int CFG_IDX_W = 2;

  // Fixed register widths and lower limits
  localparam int TARGET_W   = 16;
  localparam int RATIO_W    = 12;
  localparam int MIN_TARGET = 3;
  localparam int MIN_RATIO  = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic close;
    logic emit;
    logic last_pt;
  } op_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_BASE_DIV,
    FR_ROUTE,
    FR_NS_DIV,
    FR_SUB_DIV,
    FR_STEP
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PUSH_A,
    BK_PUSH_B,
    BK_CLOSE,
    BK_DIV_X,
    BK_DIV_Y,
    BK_PREP,
    BK_READ,
    BK_MAG,
    BK_MUL,
    BK_CMP,
    BK_FETCH,
    BK_TAKE,
    BK_EMIT
  } back_state_t;

endpackage

@@ design/minmax_lttb_downsampler_unit.sv @@
// Top level of the min/max LTTB downsampler: front, queue and back.
`timescale 1ns / 1ps
// Downsamples a series of sample_count (x, y) points, Q16.16, to the configured
// number of output points: first and last pass as they are, each middle bucket
// yields the sub-interval extreme that spans the largest triangle with the
// previous point and the bucket mean; short series pass through. A bucket sample
// passes through intake, routing and step, and a sample emitted directly through
// intake and routing; the first sample of a series adds the bucket size division
// unless the series passes through, and the first sample of every bucket (and the
// first after a register write) the sub-interval size divisions. The back works
// beside it: up to two mean divisions per bucket plus a triangle area per valid
// candidate, so a bucket close stalls the front through the two-entry queue only
// when the back falls behind. The output register takes the next point in the
// cycle the previous one is accepted.
module minmax_lttb_downsampler_unit #(
  parameter int CANDIDATE_DEPTH = 64,
  parameter int COUNT_BITS      = 24,
  parameter int DATA_BITS       = 32,
  localparam int CFG_W = (COUNT_BITS > 16) ? COUNT_BITS : 16,
  localparam int TD_W  = ((2*DATA_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mmlt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TD_W-1:0]                s_axis_tdata,  // x_value, y_value
  input  logic                           s_axis_tuser,  // y_valid
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TD_W-1:0]                m_axis_tdata,  // out_x, out_y
  output logic                           m_axis_tlast,  // is_final
  output logic [1:0]                     m_axis_tuser   // out_y_valid, all_invalid
);
  import mmlt_pkg::*;

  localparam int SW = DATA_BITS + COUNT_BITS;
  localparam int EW = $bits(op_t) + 4*DATA_BITS + 1 + 2*SW + COUNT_BITS;

  logic          q_wr, q_full, q_rd, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;
  logic signed [DATA_BITS-1:0] out_x, out_y;
  logic          out_v, out_allinv;

  mmlt_front #(
    .DATA_BITS       (DATA_BITS),
    .COUNT_BITS      (COUNT_BITS),
    .CANDIDATE_DEPTH (CANDIDATE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_x       (s_axis_tdata[DATA_BITS-1:0]),
    .s_y       (s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
    .s_v       (s_axis_tuser),
    .q_wr      (q_wr),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  mmlt_fifo #(.W(EW)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  mmlt_back #(
    .DATA_BITS       (DATA_BITS),
    .COUNT_BITS      (COUNT_BITS),
    .CANDIDATE_DEPTH (CANDIDATE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .q_data   (q_rdata),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_x      (out_x),
    .m_y      (out_y),
    .m_v      (out_v),
    .m_last   (m_axis_tlast),
    .m_allinv (out_allinv)
  );

  // Pack the output beat
  assign m_axis_tdata = TD_W'({out_y, out_x});
  assign m_axis_tuser = {out_allinv, out_v};

endmodule

@@ design/mmlt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mmlt_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ design/mmlt_fifo.sv @@
// Short queue of packed operations between front and back.
`timescale 1ns / 1ps
module mmlt_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  import mmlt_pkg::*;

  logic [W-1:0]        store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp;
  logic [QUEUE_AW-1:0] rp;
  logic [QUEUE_AW:0]   cnt;

  assign full    = cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty   = cnt == '0;
  assign rd_data = store[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + QUEUE_AW'(1);
      if (rd_en) rp <= rp + QUEUE_AW'(1);
      if (wr_en && !rd_en) cnt <= cnt + (QUEUE_AW+1)'(1);
      else if (rd_en && !wr_en) cnt <= cnt - (QUEUE_AW+1)'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) store[wp] <= wr_data;
  end

endmodule

@@ design/mmlt_front.sv @@
// Front end: sample intake, bucket bookkeeping, extremes and sums.
`timescale 1ns / 1ps
module mmlt_front #(
  parameter int DATA_BITS       = 32,
  parameter int COUNT_BITS      = 24,
  parameter int CANDIDATE_DEPTH = 64,
  localparam int CFG_W = (COUNT_BITS > 16) ? COUNT_BITS : 16,
  localparam int SW    = DATA_BITS + COUNT_BITS,
  localparam int EW    = $bits(mmlt_pkg::op_t) + 4*DATA_BITS + 1 + 2*SW + COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mmlt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic signed [DATA_BITS-1:0]       s_x,
  input  logic signed [DATA_BITS-1:0]       s_y,
  input  logic                              s_v,
  output logic                              q_wr,
  output logic [EW-1:0]                     q_data,
  input  logic                              q_full
);
  import mmlt_pkg::*;

  localparam int DB   = DATA_BITS;
  localparam int CW   = COUNT_BITS;
  localparam int NW   = CW + 5;
  localparam int VW   = TARGET_W;
  localparam int HALF = CANDIDATE_DEPTH / 2;
  localparam int SIW  = $clog2(HALF + 1);
  localparam int PW   = (CW > TARGET_W) ? CW : TARGET_W;

  front_state_t state, state_next;

  // Configuration
  logic [CW-1:0]       sample_count;
  logic [TARGET_W-1:0] goal_points;
  logic [RATIO_W-1:0]  ratio_q4;

  // Held sample
  logic signed [DB-1:0] smp_x, smp_y;
  logic                 smp_v;

  // Series and bucket state
  logic [CW-1:0]        sample_index;
  logic [TARGET_W-1:0]  bucket_number;
  logic [CW-1:0]        bucket_position;
  logic [CW-1:0]        sub_interval_position;
  logic [SIW-1:0]       sub_interval_number;
  logic signed [DB-1:0] max_x, max_y, min_x, min_y;
  logic [CW-1:0]        max_at, min_at;
  logic                 extremes_seen;
  logic signed [SW-1:0] sum_of_x, sum_of_y;
  logic [CW-1:0]        valid_sample_count;
  logic [CW-1:0]        bucket_base_size;
  logic [TARGET_W-1:0]  bucket_extra_count;
  logic                 pass_mode;
  logic                 dirty;
  logic [CW-1:0]        sub_q;
  logic [SIW-1:0]       sub_rm;

  // Divider
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [VW-1:0] div_den, div_rem;

  // Derived values
  logic [TARGET_W-1:0] tp_eff;
  logic [RATIO_W-1:0]  ratio_eff;
  logic                pass_now;
  logic                last_hit;
  logic [CW:0]         blen_raw;
  logic [CW-1:0]       blen;
  logic [CW:0]         slen;
  logic [NW-1:0]       ns_num;
  logic [VW-1:0]       ns_clamped;

  // Step values
  logic                 seed;
  logic signed [DB-1:0] nmax_x, nmax_y, nmin_x, nmin_y;
  logic [CW-1:0]        nmax_at, nmin_at;
  logic                 nseen;
  logic [CW:0]          sp1, bp1;
  logic                 sub_end, close;
  logic signed [SW-1:0] nsum_x, nsum_y;
  logic [CW-1:0]        ncnt;

  // Queue entry fields
  op_t                  q_op;
  logic signed [DB-1:0] pa_x, pa_y;
  logic                 pa_v;

  mmlt_div #(.NUM_W(NW), .DEN_W(VW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Effective registers, sizes and end tests
  always_comb begin
    tp_eff    = (goal_points < TARGET_W'(MIN_TARGET)) ? TARGET_W'(MIN_TARGET) : goal_points;
    ratio_eff = (ratio_q4 < RATIO_W'(MIN_RATIO)) ? RATIO_W'(MIN_RATIO) : ratio_q4;
    pass_now  = PW'(sample_count) <= PW'(tp_eff);
    last_hit  = ({1'b0, sample_index} + (CW+1)'(1)) >= {1'b0, sample_count};
    blen_raw  = {1'b0, bucket_base_size}
              + (CW+1)'(bucket_number < bucket_extra_count);
    blen      = (blen_raw == '0) ? CW'(1) : blen_raw[CW-1:0];
    slen      = {1'b0, sub_q} + (CW+1)'(sub_interval_number < sub_rm);
    ns_num    = NW'({blen, 4'b0000}) + NW'(ratio_eff) - NW'(1);
    if (div_quo == '0) ns_clamped = VW'(1);
    else if (div_quo > NW'(HALF)) ns_clamped = VW'(HALF);
    else ns_clamped = div_quo[VW-1:0];
  end

  // Extremes, positions and sums for one bucket sample
  always_comb begin
    seed    = (sub_interval_position == '0) || (smp_v && !extremes_seen);
    nmax_x  = max_x;
    nmax_y  = max_y;
    nmin_x  = min_x;
    nmin_y  = min_y;
    nmax_at = max_at;
    nmin_at = min_at;
    nseen   = extremes_seen;
    if (seed) begin
      nmax_x  = smp_x;
      nmax_y  = smp_y;
      nmin_x  = smp_x;
      nmin_y  = smp_y;
      nmax_at = sub_interval_position;
      nmin_at = sub_interval_position;
      nseen   = smp_v;
    end else if (smp_v) begin
      if (smp_y > max_y) begin
        nmax_x  = smp_x;
        nmax_y  = smp_y;
        nmax_at = sub_interval_position;
      end
      if (smp_y < min_y) begin
        nmin_x  = smp_x;
        nmin_y  = smp_y;
        nmin_at = sub_interval_position;
      end
    end
    sp1     = {1'b0, sub_interval_position} + (CW+1)'(1);
    bp1     = {1'b0, bucket_position} + (CW+1)'(1);
    sub_end = sp1 >= slen;
    close   = bp1 >= {1'b0, blen};
    nsum_x  = smp_v ? sum_of_x + SW'(smp_x) : sum_of_x;
    nsum_y  = smp_v ? sum_of_y + SW'(smp_y) : sum_of_y;
    ncnt    = smp_v ? valid_sample_count + CW'(1) : valid_sample_count;
  end

  // Next state, divider requests and queue writes
  always_comb begin
    state_next = state;
    s_ready    = 1'b0;
    q_wr       = 1'b0;
    q_op       = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    pa_x       = nmax_x;
    pa_y       = nmax_y;
    pa_v       = nseen;
    unique case (state)
      FR_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          if (sample_index == '0 && !pass_now) begin
            div_start  = 1'b1;
            div_num    = NW'(sample_count - CW'(2));
            div_den    = VW'(tp_eff - TARGET_W'(2));
            state_next = FR_BASE_DIV;
          end else begin
            state_next = FR_ROUTE;
          end
        end
      end
      FR_BASE_DIV: begin
        if (div_done) state_next = FR_ROUTE;
      end
      FR_ROUTE: begin
        if (last_hit || sample_index == '0 || pass_mode) begin
          pa_x = smp_x;
          pa_y = smp_y;
          pa_v = smp_v;
          if (!q_full) begin
            q_wr         = 1'b1;
            q_op.emit    = 1'b1;
            q_op.last_pt = last_hit;
            state_next   = FR_IDLE;
          end
        end else if (dirty) begin
          div_start  = 1'b1;
          div_num    = ns_num;
          div_den    = VW'(ratio_eff);
          state_next = FR_NS_DIV;
        end else begin
          state_next = FR_STEP;
        end
      end
      FR_NS_DIV: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = NW'(blen);
          div_den    = ns_clamped;
          state_next = FR_SUB_DIV;
        end
      end
      FR_SUB_DIV: begin
        if (div_done) state_next = FR_STEP;
      end
      FR_STEP: begin
        if (!q_full) begin
          q_op.push_a = sub_end;
          q_op.push_b = sub_end && nseen && (nmax_at != nmin_at);
          q_op.close  = close;
          q_wr        = sub_end || close;
          state_next  = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign q_data = {q_op, pa_x, pa_y, pa_v, nmin_x, nmin_y, nsum_x, nsum_y, ncnt};

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else state <= state_next;
  end

  // Held sample
  always_ff @(posedge clk) begin
    if (state == FR_IDLE && s_valid) begin
      smp_x <= s_x;
      smp_y <= s_y;
      smp_v <= s_v;
    end
  end

  // Configuration and series bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count          <= CW'(1);
      goal_points           <= TARGET_W'(MIN_TARGET);
      ratio_q4              <= RATIO_W'(MIN_RATIO);
      sample_index          <= '0;
      bucket_number         <= '0;
      bucket_position       <= '0;
      sub_interval_position <= '0;
      sub_interval_number   <= '0;
      max_x                 <= '0;
      max_y                 <= '0;
      min_x                 <= '0;
      min_y                 <= '0;
      max_at                <= '0;
      min_at                <= '0;
      extremes_seen         <= 1'b0;
      sum_of_x              <= '0;
      sum_of_y              <= '0;
      valid_sample_count    <= '0;
      bucket_base_size      <= '0;
      bucket_extra_count    <= '0;
      pass_mode             <= 1'b0;
      dirty                 <= 1'b1;
      sub_q                 <= '0;
      sub_rm                <= '0;
    end else begin
      unique case (state)
        FR_IDLE: begin
          if (s_valid && sample_index == '0) begin
            pass_mode          <= pass_now;
            bucket_base_size   <= '0;
            bucket_extra_count <= '0;
            dirty              <= 1'b1;
          end
        end
        FR_BASE_DIV: begin
          if (div_done) begin
            bucket_base_size   <= div_quo[CW-1:0];
            bucket_extra_count <= div_rem;
          end
        end
        FR_ROUTE: begin
          if ((last_hit || sample_index == '0 || pass_mode) && !q_full) begin
            if (last_hit) begin
              // End of series: return to the starting point
              sample_index          <= '0;
              bucket_number         <= '0;
              bucket_position       <= '0;
              sub_interval_position <= '0;
              sub_interval_number   <= '0;
              extremes_seen         <= 1'b0;
              sum_of_x              <= '0;
              sum_of_y              <= '0;
              valid_sample_count    <= '0;
            end else begin
              sample_index <= sample_index + CW'(1);
            end
          end
        end
        FR_NS_DIV: ;
        FR_SUB_DIV: begin
          if (div_done) begin
            sub_q  <= div_quo[CW-1:0];
            sub_rm <= div_rem[SIW-1:0];
            dirty  <= 1'b0;
          end
        end
        FR_STEP: begin
          if (!q_full) begin
            sample_index <= sample_index + CW'(1);
            max_x        <= nmax_x;
            max_y        <= nmax_y;
            min_x        <= nmin_x;
            min_y        <= nmin_y;
            max_at       <= nmax_at;
            min_at       <= nmin_at;
            // Close the sub-interval
            if (sub_end) begin
              sub_interval_position <= '0;
              sub_interval_number   <= sub_interval_number + SIW'(1);
              extremes_seen         <= 1'b0;
            end else begin
              sub_interval_position <= sp1[CW-1:0];
              extremes_seen         <= nseen;
            end
            // Close the bucket
            if (close) begin
              bucket_position       <= '0;
              sub_interval_position <= '0;
              sub_interval_number   <= '0;
              extremes_seen         <= 1'b0;
              sum_of_x              <= '0;
              sum_of_y              <= '0;
              valid_sample_count    <= '0;
              dirty                 <= 1'b1;
              if (bucket_number != {TARGET_W{1'b1}}) begin
                bucket_number <= bucket_number + TARGET_W'(1);
              end
            end else begin
              bucket_position    <= bp1[CW-1:0];
              sum_of_x           <= nsum_x;
              sum_of_y           <= nsum_y;
              valid_sample_count <= ncnt;
            end
          end
        end
        default: ;
      endcase
      // Register writes; any write forces the sub-interval sizes again
      if (cfg_we) begin
        dirty <= 1'b1;
        case (cfg_index)
          REG_SAMPLE_COUNT: sample_count <= cfg_data[CW-1:0];
          REG_GOAL_POINTS:  goal_points  <= cfg_data[TARGET_W-1:0];
          REG_RATIO_Q4:     ratio_q4     <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/mmlt_back.sv @@
// Back end: candidate store, bucket mean, triangle-area selection and output.
`timescale 1ns / 1ps
module mmlt_back #(
  parameter int DATA_BITS       = 32,
  parameter int COUNT_BITS      = 24,
  parameter int CANDIDATE_DEPTH = 64,
  localparam int SW = DATA_BITS + COUNT_BITS,
  localparam int EW = $bits(mmlt_pkg::op_t) + 4*DATA_BITS + 1 + 2*SW + COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_rd,
  input  logic [EW-1:0]               q_data,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic signed [DATA_BITS-1:0] m_x,
  output logic signed [DATA_BITS-1:0] m_y,
  output logic                        m_v,
  output logic                        m_last,
  output logic                        m_allinv
);
  import mmlt_pkg::*;

  localparam int DB  = DATA_BITS;
  localparam int CW  = COUNT_BITS;
  localparam int IW  = $clog2(CANDIDATE_DEPTH);
  localparam int TW  = $clog2(CANDIDATE_DEPTH + 1);
  localparam int MW  = 2*DB + 1;
  localparam int XW  = DB + 2;
  localparam int AW  = 2*DB + 1;
  localparam int OPW = $bits(op_t);

  back_state_t state, state_next;

  // Queue entry, live and held
  op_t                  q_op, e_op;
  logic signed [DB-1:0] q_pa_x, q_pa_y, e_pa_x, e_pa_y, e_pb_x, e_pb_y;
  logic                 q_pa_v, e_pa_v;
  logic signed [SW-1:0] e_sx, e_sy;
  logic [CW-1:0]        e_cnt;
  logic [EW-1:0]        ent;

  // Candidate store
  logic [MW-1:0] cand_mem [CANDIDATE_DEPTH];
  logic [MW-1:0] rdata;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [MW-1:0] mem_wdata;
  logic [TW-1:0] cand_total;

  // Selection
  logic signed [DB-1:0] last_x, last_y;
  logic                 last_v, any_valid;
  logic signed [XW-1:0] mx, my;
  logic [DB-1:0]        amag, bmag, cmag, dmag;
  logic                 aneg, bneg, cneg, dneg;
  logic [2*DB-1:0]      prod_p, prod_q;
  logic                 psg, qsg;
  logic [AW-1:0]        area, best_area;
  logic [TW-1:0]        idx;
  logic [IW-1:0]        best;
  logic                 found;
  logic signed [DB-1:0] emit_x, emit_y;
  logic                 emit_v;

  // Mean divider
  logic          div_start, div_done;
  logic [SW-1:0] div_num, div_quo;
  logic [CW-1:0] div_rem;
  logic signed [XW-1:0] mean;
  logic [SW-1:0] mag_sx, mag_sy;

  // Difference terms
  logic signed [DB-1:0] rx, ry;
  logic                 rv;
  logic signed [XW-1:0] da, db_, dc, dd;
  logic                 out_free;

  assign q_op = op_t'(q_data[EW-1 -: OPW]);
  assign {q_pa_x, q_pa_y, q_pa_v} = q_data[EW-OPW-1 -: 2*DB+1];
  assign {e_op, e_pa_x, e_pa_y, e_pa_v, e_pb_x, e_pb_y, e_sx, e_sy, e_cnt} = ent;
  assign {rv, ry, rx} = rdata;
  assign out_free = !m_valid || m_ready;

  mmlt_div #(.NUM_W(SW), .DEN_W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (e_cnt),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Magnitudes, signed mean and the area of the current candidate
  always_comb begin
    mag_sx = e_sx[SW-1] ? SW'(-e_sx) : SW'(e_sx);
    mag_sy = e_sy[SW-1] ? SW'(-e_sy) : SW'(e_sy);
    mean   = {1'b0, div_quo[DB:0]};
    if ((state == BK_DIV_X && e_sx[SW-1]) || (state == BK_DIV_Y && e_sy[SW-1])) begin
      mean = -mean;
    end
    da  = XW'(rx) - XW'(last_x);
    dd  = XW'(ry) - XW'(last_y);
    db_ = my - XW'(last_y);
    dc  = mx - XW'(last_x);
    if (psg != qsg) area = {1'b0, prod_p} + {1'b0, prod_q};
    else if (prod_p >= prod_q) area = {1'b0, prod_p - prod_q};
    else area = {1'b0, prod_q - prod_p};
  end

  // Next state, queue pops, store writes and divider requests
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = {e_pa_v, e_pa_y, e_pa_x};
    div_start  = 1'b0;
    div_num    = mag_sx;
    rd_addr    = idx[IW-1:0];
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (q_op.push_a) state_next = BK_PUSH_A;
          else if (q_op.close) state_next = BK_CLOSE;
          else if (q_op.emit) state_next = BK_EMIT;
        end
      end
      BK_PUSH_A: begin
        mem_we = cand_total < TW'(CANDIDATE_DEPTH);
        if (e_op.push_b) state_next = BK_PUSH_B;
        else if (e_op.close) state_next = BK_CLOSE;
        else state_next = BK_IDLE;
      end
      BK_PUSH_B: begin
        mem_we    = cand_total < TW'(CANDIDATE_DEPTH);
        mem_wdata = {1'b1, e_pb_y, e_pb_x};
        state_next = e_op.close ? BK_CLOSE : BK_IDLE;
      end
      BK_CLOSE: begin
        if (e_cnt != '0 && last_v) begin
          div_start  = 1'b1;
          state_next = BK_DIV_X;
        end else begin
          state_next = BK_FETCH;
        end
      end
      BK_DIV_X: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = mag_sy;
          state_next = BK_DIV_Y;
        end
      end
      BK_DIV_Y: begin
        if (div_done) state_next = BK_PREP;
      end
      BK_PREP:  state_next = BK_READ;
      BK_READ:  state_next = (idx >= cand_total) ? BK_FETCH : BK_MAG;
      BK_MAG:   state_next = rv ? BK_MUL : BK_READ;
      BK_MUL:   state_next = BK_CMP;
      BK_CMP:   state_next = BK_READ;
      BK_FETCH: begin
        rd_addr    = best;
        state_next = BK_TAKE;
      end
      BK_TAKE:  state_next = BK_EMIT;
      BK_EMIT: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // Candidate store
  always_ff @(posedge clk) begin
    if (mem_we) cand_mem[cand_total[IW-1:0]] <= mem_wdata;
    rdata <= cand_mem[rd_addr];
  end

  // Selection datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          ent    <= q_data;
          emit_x <= q_pa_x;
          emit_y <= q_pa_y;
          emit_v <= q_pa_v;
        end
      end
      BK_CLOSE: begin
        best  <= '0;
        found <= 1'b0;
        idx   <= '0;
      end
      BK_DIV_X: begin
        if (div_done) mx <= mean;
      end
      BK_DIV_Y: begin
        if (div_done) my <= mean;
      end
      BK_PREP: begin
        bneg <= db_[XW-1];
        bmag <= db_[XW-1] ? DB'(-db_) : DB'(db_);
        cneg <= dc[XW-1];
        cmag <= dc[XW-1] ? DB'(-dc) : DB'(dc);
      end
      BK_MAG: begin
        aneg <= da[XW-1];
        amag <= da[XW-1] ? DB'(-da) : DB'(da);
        dneg <= dd[XW-1];
        dmag <= dd[XW-1] ? DB'(-dd) : DB'(dd);
        if (!rv) idx <= idx + TW'(1);
      end
      BK_MUL: begin
        prod_p <= amag * bmag;
        prod_q <= cmag * dmag;
        psg    <= aneg ^ bneg;
        qsg    <= cneg ^ dneg;
      end
      BK_CMP: begin
        // First of equal areas keeps its place
        if (!found || area > best_area) begin
          found     <= 1'b1;
          best      <= idx[IW-1:0];
          best_area <= area;
        end
        idx <= idx + TW'(1);
      end
      BK_TAKE: begin
        emit_x <= rdata[DB-1:0];
        emit_y <= rdata[2*DB-1:DB];
        emit_v <= rdata[2*DB];
      end
      default: ;
    endcase
  end

  // Candidate count, history of emitted points and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_total <= '0;
      last_x     <= '0;
      last_y     <= '0;
      last_v     <= 1'b0;
      any_valid  <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if ((state == BK_PUSH_A || state == BK_PUSH_B) && mem_we) begin
        cand_total <= cand_total + TW'(1);
      end
      if (state == BK_TAKE) cand_total <= '0;
      if (state == BK_EMIT && out_free) begin
        m_valid <= 1'b1;
        if (e_op.last_pt) begin
          last_x     <= '0;
          last_y     <= '0;
          last_v     <= 1'b0;
          any_valid  <= 1'b0;
          cand_total <= '0;
        end else begin
          last_x    <= emit_x;
          last_y    <= emit_y;
          last_v    <= emit_v;
          any_valid <= any_valid || emit_v;
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (state == BK_EMIT && out_free) begin
      m_x      <= emit_x;
      m_y      <= emit_y;
      m_v      <= emit_v;
      m_last   <= e_op.last_pt;
      m_allinv <= e_op.last_pt && !(any_valid || emit_v);
    end
  end

  // The store never holds more candidates than it has entries
  assert property (@(posedge clk) disable iff (rst)
    cand_total <= TW'(CANDIDATE_DEPTH))
    else $error("candidate count beyond store depth");

  // The discard flag only rides on the last point of a series
  assert property (@(posedge clk) disable iff (rst)
    m_valid && m_allinv |-> m_last)
    else $error("all_invalid on a point that is not final");

  // A point handed to a free output register shows up as a beat
  assert property (@(posedge clk) disable iff (rst)
    state == BK_EMIT && out_free |=> m_valid)
    else $error("emitted point lost");

endmodule

@@ tb/minmax_lttb_downsampler_unit_test.sv @@
// Self-checking testbench of the min/max LTTB downsampler: random series against a local predictor.
`timescale 1ns / 1ps
module minmax_lttb_downsampler_unit_test;
  import mmlt_pkg::*;

  localparam int CAND_DEPTH = 64;
  localparam int CFG_W = 24;
  localparam int TD_W = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } pt_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        yv;
  } sample_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        yv;
    logic        fin;
    logic        allinv;
  } point_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TD_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TD_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;

  minmax_lttb_downsampler_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  int unsigned n_samples, n_target, ratio;
  int unsigned idx, bkt, bpos, spos, snum, cand_n, base_sz, extra_n, max_pos, min_pos;
  pt_t run_max, run_min, last_pt;
  logic seen, any_valid, last_valid, passthru;
  logic signed [63:0] sx, sy;
  int unsigned vcount;
  pt_t cand_pt [CAND_DEPTH];
  logic cand_ok [CAND_DEPTH];

  sample_t pending_samples[$];
  point_out_t expected_points[$];
  int errors = 0;
  int cycles = 0;
  int n_out = 0;
  int n_in = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit quiet = 0;

  function automatic void clear_bucket();
    bpos = 0; spos = 0; snum = 0; seen = 0; sx = 0; sy = 0; vcount = 0; cand_n = 0;
  endfunction

  function automatic void clear_series();
    idx = 0; bkt = 0; clear_bucket();
    last_pt.x = 0; last_pt.y = 0; last_valid = 0; any_valid = 0;
  endfunction

  function automatic void emit_point(pt_t p, logic v, logic fin);
    point_out_t o;
    any_valid = any_valid | v;
    o.x = p.x[31:0]; o.y = p.y[31:0]; o.yv = v; o.fin = fin;
    o.allinv = fin & ~any_valid;
    expected_points.insert(expected_points.size(), o);
    last_pt = p; last_valid = v;
  endfunction

  function automatic void push_candidate(pt_t p, logic v);
    if (cand_n < CAND_DEPTH) begin
      cand_pt[cand_n] = p; cand_ok[cand_n] = v; cand_n++;
    end
  endfunction

  // Pick the candidate of largest triangle area; ties keep the first
  function automatic void close_bucket();
    logic signed [63:0] mx, my, a, b, c, d;
    logic signed [129:0] ar, best_ar;
    int unsigned best;
    bit found;
    best = 0; found = 0; best_ar = 0;
    if (vcount > 0 && last_valid) begin
      mx = sx / $signed({32'd0, vcount});
      my = sy / $signed({32'd0, vcount});
      for (int i = 0; i < cand_n; i++) begin
        if (cand_ok[i]) begin
          a = cand_pt[i].x - last_pt.x; b = my - last_pt.y;
          c = mx - last_pt.x; d = cand_pt[i].y - last_pt.y;
          ar = 130'(a) * 130'(b) - 130'(c) * 130'(d);
          if (ar < 0) ar = -ar;
          if (!found || ar > best_ar) begin
            found = 1; best = i; best_ar = ar;
          end
        end
      end
    end
    emit_point(cand_pt[best], cand_ok[best], 1'b0);
  endfunction

  function automatic void predict_sample(sample_t s);
    pt_t p;
    int unsigned tp, r, blen, ns, slen;
    longint unsigned t;
    p.x = 64'($signed(s.x)); p.y = 64'($signed(s.y));
    tp = n_target < 3 ? 3 : n_target;
    if (idx == 0) begin
      passthru = n_samples <= tp;
      base_sz = 0; extra_n = 0;
      if (!passthru) begin
        base_sz = (n_samples - 2) / (tp - 2);
        extra_n = (n_samples - 2) % (tp - 2);
      end
    end
    if (64'(idx) + 1 >= 64'(n_samples)) begin
      emit_point(p, s.yv, 1'b1);
      clear_series();
      return;
    end
    if (idx == 0 || passthru) begin
      emit_point(p, s.yv, 1'b0);
      idx = (idx + 1) & 24'hFFFFFF;
      return;
    end
    idx = (idx + 1) & 24'hFFFFFF;
    blen = base_sz + (bkt < extra_n ? 1 : 0);
    if (blen == 0) blen = 1;
    r = ratio < 32 ? 32 : ratio;
    t = (64'(blen) * 16 + r - 1) / r;
    ns = t < 1 ? 1 : (t > CAND_DEPTH / 2 ? CAND_DEPTH / 2 : int'(t));
    slen = blen / ns + (snum < blen % ns ? 1 : 0);
    if (s.yv) begin
      sx += p.x; sy += p.y; vcount++;
    end
    if (spos == 0 || (s.yv && !seen)) begin
      run_max = p; run_min = p; max_pos = spos; min_pos = spos; seen = s.yv;
    end else if (s.yv) begin
      if (p.y > run_max.y) begin run_max = p; max_pos = spos; end
      if (p.y < run_min.y) begin run_min = p; min_pos = spos; end
    end
    spos++;
    if (spos >= slen) begin
      push_candidate(run_max, seen);
      if (seen && max_pos != min_pos) push_candidate(run_min, 1'b1);
      spos = 0; snum++; seen = 0;
    end
    bpos++;
    if (bpos >= blen) begin
      close_bucket();
      if (bkt < 16'hFFFF) bkt++;
      clear_bucket();
    end
  endfunction

  // Drive: offer queued samples, predict on each accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample('{s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser});
        n_in++;
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_samples.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
          sample_t s;
          s = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {s.y, s.x};
          s_axis_tuser <= s.yv;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off: count the stall in cycles once it is requested
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      hold_cnt <= 300;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each accepted output beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        point_out_t e;
        n_out++;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat x=%h y=%h", $time, m_axis_tdata[31:0],
                   m_axis_tdata[63:32]);
        end else begin
          e = expected_points.pop_front();
          if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
              m_axis_tuser[0] !== e.yv || m_axis_tlast !== e.fin ||
              m_axis_tuser[1] !== e.allinv || m_axis_tdata[63:64-1] === 1'bx) begin
            errors++;
            $display("%0t: mismatch expected x=%h y=%h v=%b last=%b ai=%b", $time,
                     e.x, e.y, e.yv, e.fin, e.allinv);
            $display("%0t:          actual   x=%h y=%h v=%b last=%b ai=%b", $time,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0],
                     m_axis_tlast, m_axis_tuser[1]);
          end
        end
      end
      m_axis_tready <= (hold_cnt == 0) && (quiet || $urandom_range(99) >= 15);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[minmax_lttb_downsampler_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= i; cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (i)
      REG_SAMPLE_COUNT: n_samples = v & 24'hFFFFFF;
      REG_GOAL_POINTS: n_target = v & 16'hFFFF;
      default: ratio = v & 12'hFFF;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned nsamp, input int unsigned ntgt,
                            input int unsigned r);
    drain();
    write_reg(REG_SAMPLE_COUNT, nsamp);
    write_reg(REG_GOAL_POINTS, ntgt);
    write_reg(REG_RATIO_Q4, r);
  endtask

  // Queue one series; mostly valid, with extremes, ties and NaN runs mixed in
  task automatic queue_series(input int unsigned len, input int mode);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s.x = (mode == 1) ? $urandom : 32'(i * 65536);
      case ($urandom_range(9))
        0: s.y = 32'h7FFFFFFF;
        1: s.y = 32'h80000000;
        2: s.y = 32'h00010000;
        default: s.y = (mode == 1) ? $urandom : 32'($signed($urandom_range(2000)) - 1000) <<< 12;
      endcase
      s.yv = (mode == 2) ? 1'b0 : ($urandom_range(99) >= 12);
      pending_samples.insert(pending_samples.size(), s);
    end
  endtask

  initial begin
    int unsigned nsamp, ntgt, r;
    n_samples = 1; n_target = 3; ratio = 32;
    clear_series();
    base_sz = 0; extra_n = 0; passthru = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample series at reset settings, pass-through, extremes, all-NaN
    queue_series(2, 1);
    set_config(3, 3, 32);
    queue_series(3, 1);
    set_config(12, 3, 4095);
    queue_series(12, 1);
    set_config(10, 4, 32);
    queue_series(10, 2);

    // Random phases across settings
    while (n_in < 1250) begin
      nsamp = $urandom_range(4, 120);
      ntgt = $urandom_range(3, 12);
      r = ($urandom_range(3) == 0) ? 4095 : $urandom_range(32, 200);
      if ($urandom_range(7) == 0) ntgt = 65535;
      set_config(nsamp, ntgt, r);
      quiet = ($urandom_range(5) == 0);
      for (int k = 0; k < 3; k++) queue_series(nsamp, $urandom_range(9) == 0 ? 2 :
                                                       ($urandom_range(3) == 0));
      // Long receiver hold-off once, while the sender keeps offering
      if (!hold_req && n_in > 300) hold_req = 1;
      while (pending_samples.size() > 0) @(posedge clk);
    end
    quiet = 0;
    drain();
    $display("Covered %0d samples and %0d output points over random series settings,",
             n_in, n_out);
    $display("including pass-through, all-invalid series and a long output stall.");
    if (errors == 0) begin
      $display("[minmax_lttb_downsampler_unit] OK");
    end else begin
      $display("[minmax_lttb_downsampler_unit] ERROR");
    end
    $finish;
  end

endmodule
